[rtl/core/sdtq_pkg.sv]
// ============================================================================
// sdtq_pkg : shared types and constants of the sorted deadline timer queue
// Default sizes, field widths and the codes used across the queue files.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package sdtq_pkg;

    localparam int DEF_NUM_TIMERS = 16;
    localparam int DEF_TIME_BITS  = 40;

    localparam int FUNC_W  = 2;
    localparam int ID_W    = 4;
    localparam int NOW_W   = 40;
    localparam int DELAY_W = 32;
    localparam int STAT_W  = 2;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_START  = 2'd0,
        FUNC_STOP   = 2'd1,
        FUNC_EXPIRE = 2'd2
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE   = 2'd0,
        ST_REJECT = 2'd1,
        ST_FIRED  = 2'd2
    } status_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

endpackage

`default_nettype wire

[rtl/core/sdtq_ram.sv]
// ============================================================================
// sdtq_ram : generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sdtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/core/sdtq_alu.sv]
// ============================================================================
// sdtq_alu : shared add / compare unit
// Adds for deadline computation, subtracts for deadline ordering; the carry
// out flags overflow on add and y <= x on subtract.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sdtq_alu
    import sdtq_pkg::*;
#(
    parameter int W = DEF_TIME_BITS
) (
    input  wire alu_op_t      op,
    input  wire logic [W-1:0] x,
    input  wire logic [W-1:0] y,
    output logic      [W-1:0] res,
    output logic              carry
);

    logic [W:0] full;
    logic [W-1:0] y_in;

    always_comb
    begin
        y_in  = (op == ALU_SUB) ? ~y : y;
        full  = {1'b0, x} + {1'b0, y_in} + {{W{1'b0}}, (op == ALU_SUB)};
        res   = full[W-1:0];
        carry = full[W];
    end

endmodule

`default_nettype wire

[rtl/core/sorted_deadline_timer_queue.sv]
// ============================================================================
// sorted_deadline_timer_queue : deadline-sorted one-shot timer queue
// Start, stop and expire commands on a RAM-held queue sorted by deadline,
// walked one entry at a time through a shared add / compare unit.
// ============================================================================
//
//  channel | dir | tdata                          | tuser    | tlast
//  --------+-----+--------------------------------+----------+------
//  s_      | in  | timer_id, now_ms, delay_ms     | func     | -
//  m_      | out | fired_id                       | status   | last
//
//  Each queue entry is handled as a RAM read, then a compare/write. A start
//  walks back over the entries with a later deadline, a stop over the whole
//  queue; an expire walks the due entries and, if any fired, moves the rest
//  down to the head.
//  Reset empties the queue and clears all running flags at once.
//  A stalled output holds the sequencer only where it must emit a result.
//
`timescale 1ns / 1ps
`default_nettype none

module sorted_deadline_timer_queue
    import sdtq_pkg::*;
#(
    parameter int NUM_TIMERS = DEF_NUM_TIMERS,
    parameter int TIME_BITS  = DEF_TIME_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // timer_id[3:0], now_ms[43:4], delay_ms[75:44]
    input  wire logic [FUNC_W-1:0]     s_tuser,   // func[1:0]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [OUT_DATA_W-1:0] m_tdata,   // fired_id[3:0]
    output logic      [STAT_W-1:0]     m_tuser,   // status[1:0]
    output logic                       m_tlast
);

    localparam int IDX_W = $clog2(NUM_TIMERS);
    localparam int CNT_W = $clog2(NUM_TIMERS + 1);
    localparam int ENT_W = ID_W + TIME_BITS;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_INS_RD  = 11'b000_0000_0010,
        S_INS_CHK = 11'b000_0000_0100,
        S_STP_RD  = 11'b000_0000_1000,
        S_STP_CHK = 11'b000_0001_0000,
        S_EXP_RD  = 11'b000_0010_0000,
        S_EXP_CHK = 11'b000_0100_0000,
        S_EXP_END = 11'b000_1000_0000,
        S_SH_RD   = 11'b001_0000_0000,
        S_SH_WR   = 11'b010_0000_0000,
        S_RESP    = 11'b100_0000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [NUM_TIMERS-1:0] running_reg, running_next;
    logic [ID_W-1:0]       cmd_id_reg, cmd_id_next;
    logic [TIME_BITS-1:0]  cmd_time_reg, cmd_time_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      dst_reg, dst_next;
    logic                  found_reg, found_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]       pend_id_reg, pend_id_next;
    status_t               resp_reg, resp_next;

    logic                  m_valid_reg;
    status_t               m_status_reg;
    logic [ID_W-1:0]       m_id_reg;
    logic                  m_last_reg;

    logic [FUNC_W-1:0]     in_func;
    logic [ID_W-1:0]       in_id;
    logic [TIME_BITS-1:0]  in_now;
    logic [DELAY_W-1:0]    in_delay;
    logic                  in_id_ok;
    logic [IDX_W-1:0]      in_idx;
    logic [IDX_W-1:0]      cmd_idx;
    logic [CNT_W-1:0]      idx_dec;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [ENT_W-1:0]      ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [ENT_W-1:0]      rd_data;
    logic [TIME_BITS-1:0]  rd_deadline;
    logic [ID_W-1:0]       rd_id;
    logic [IDX_W-1:0]      rd_idx;

    alu_op_t               alu_op;
    logic [TIME_BITS-1:0]  alu_x;
    logic [TIME_BITS-1:0]  alu_y;
    logic [TIME_BITS-1:0]  alu_res;
    logic                  alu_carry;

    logic                  out_free;
    logic                  out_load;
    status_t               out_status;
    logic [ID_W-1:0]       out_id;
    logic                  out_last;

    assign in_func     = s_tuser;
    assign in_id       = s_tdata[3:0];
    assign in_now      = TIME_BITS'(s_tdata[43:4]);
    assign in_delay    = s_tdata[75:44];
    assign in_id_ok    = (32'(in_id) < NUM_TIMERS);
    assign in_idx      = IDX_W'(in_id);
    assign cmd_idx     = IDX_W'(cmd_id_reg);
    assign idx_dec     = idx_reg - CNT_W'(1);
    assign rd_deadline = rd_data[TIME_BITS-1:0];
    assign rd_id       = rd_data[ENT_W-1:TIME_BITS];
    assign rd_idx      = IDX_W'(rd_id);
    assign out_free    = !m_valid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_id_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    sdtq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_TIMERS)
    ) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    sdtq_alu #(
        .W (TIME_BITS)
    ) u_alu (
        .op    (alu_op),
        .x     (alu_x),
        .y     (alu_y),
        .res   (alu_res),
        .carry (alu_carry)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        running_next    = running_reg;
        cmd_id_next     = cmd_id_reg;
        cmd_time_next   = cmd_time_reg;
        idx_next        = idx_reg;
        dst_next        = dst_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        resp_next       = resp_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_raddr       = '0;
        out_load        = 1'b0;
        out_status      = ST_DONE;
        out_id          = '0;
        out_last        = 1'b1;
        alu_op          = ALU_SUB;
        alu_x           = cmd_time_reg;
        alu_y           = rd_deadline;

        case (state_reg)
            S_IDLE:
            begin
                alu_op = ALU_ADD;
                alu_x  = in_now;
                alu_y  = TIME_BITS'(in_delay);
                if (s_tvalid)
                begin
                    cmd_id_next     = in_id;
                    idx_next        = '0;
                    dst_next        = '0;
                    found_next      = 1'b0;
                    pend_valid_next = 1'b0;
                    resp_next       = ST_DONE;
                    state_next      = S_RESP;
                    case (in_func)
                        FUNC_START:
                        begin
                            cmd_time_next = alu_carry ? '1 : alu_res;
                            idx_next      = count_reg;
                            if (in_id_ok)
                            begin
                                if (running_reg[in_idx] || count_reg >= CNT_W'(NUM_TIMERS))
                                begin
                                    resp_next = ST_REJECT;
                                end
                                else
                                begin
                                    state_next = S_INS_RD;
                                end
                            end
                        end
                        FUNC_STOP:
                        begin
                            if (in_id_ok && running_reg[in_idx])
                            begin
                                state_next = S_STP_RD;
                            end
                        end
                        FUNC_EXPIRE:
                        begin
                            cmd_time_next = in_now;
                            state_next    = S_EXP_RD;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_INS_RD:
            begin
                ram_raddr = idx_dec[IDX_W-1:0];
                if (idx_reg == '0)
                begin
                    ram_we                = 1'b1;
                    ram_waddr             = '0;
                    ram_wdata             = {cmd_id_reg, cmd_time_reg};
                    count_next            = count_reg + CNT_W'(1);
                    running_next[cmd_idx] = 1'b1;
                    state_next            = S_RESP;
                end
                else
                begin
                    state_next = S_INS_CHK;
                end
            end

            S_INS_CHK:
            begin
                ram_raddr = idx_dec[IDX_W-1:0];
                ram_we    = 1'b1;
                ram_waddr = idx_reg[IDX_W-1:0];
                if (alu_carry)
                begin
                    ram_wdata             = {cmd_id_reg, cmd_time_reg};
                    count_next            = count_reg + CNT_W'(1);
                    running_next[cmd_idx] = 1'b1;
                    state_next            = S_RESP;
                end
                else
                begin
                    ram_wdata  = rd_data;
                    idx_next   = idx_dec;
                    state_next = S_INS_RD;
                end
            end

            S_STP_RD:
            begin
                ram_raddr = idx_reg[IDX_W-1:0];
                if (idx_reg == count_reg)
                begin
                    count_next            = count_reg - CNT_W'(1);
                    running_next[cmd_idx] = 1'b0;
                    state_next            = S_RESP;
                end
                else
                begin
                    state_next = S_STP_CHK;
                end
            end

            S_STP_CHK:
            begin
                ram_raddr = idx_reg[IDX_W-1:0];
                if (found_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_dec[IDX_W-1:0];
                    ram_wdata = rd_data;
                end
                else if (rd_id == cmd_id_reg)
                begin
                    found_next = 1'b1;
                end
                idx_next   = idx_reg + CNT_W'(1);
                state_next = S_STP_RD;
            end

            S_EXP_RD:
            begin
                ram_raddr = idx_reg[IDX_W-1:0];
                state_next = (idx_reg == count_reg) ? S_EXP_END : S_EXP_CHK;
            end

            S_EXP_CHK:
            begin
                ram_raddr = idx_reg[IDX_W-1:0];
                if (alu_carry)
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_load   = 1'b1;
                            out_status = ST_FIRED;
                            out_id     = pend_id_reg;
                            out_last   = 1'b0;
                        end
                        pend_valid_next      = 1'b1;
                        pend_id_next         = rd_id;
                        running_next[rd_idx] = 1'b0;
                        idx_next             = idx_reg + CNT_W'(1);
                        state_next           = S_EXP_RD;
                    end
                end
                else
                begin
                    state_next = S_EXP_END;
                end
            end

            S_EXP_END:
            begin
                if (!pend_valid_reg)
                begin
                    resp_next  = ST_DONE;
                    state_next = S_RESP;
                end
                else if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status      = ST_FIRED;
                    out_id          = pend_id_reg;
                    out_last        = 1'b1;
                    pend_valid_next = 1'b0;
                    dst_next        = '0;
                    state_next      = S_SH_RD;
                end
            end

            S_SH_RD:
            begin
                ram_raddr = idx_reg[IDX_W-1:0];
                if (idx_reg == count_reg)
                begin
                    count_next = dst_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SH_WR;
                end
            end

            S_SH_WR:
            begin
                ram_raddr  = idx_reg[IDX_W-1:0];
                ram_we     = 1'b1;
                ram_waddr  = dst_reg[IDX_W-1:0];
                ram_wdata  = rd_data;
                dst_next   = dst_reg + CNT_W'(1);
                idx_next   = idx_reg + CNT_W'(1);
                state_next = S_SH_RD;
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_status = resp_reg;
                    out_id     = '0;
                    out_last   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            running_reg    <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            running_reg    <= running_next;
            pend_valid_reg <= pend_valid_next;
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_id_reg   <= cmd_id_next;
        cmd_time_reg <= cmd_time_next;
        idx_reg      <= idx_next;
        dst_reg      <= dst_next;
        found_reg    <= found_next;
        pend_id_reg  <= pend_id_next;
        resp_reg     <= resp_next;
        if (out_load)
        begin
            m_status_reg <= out_status;
            m_id_reg     <= out_id;
            m_last_reg   <= out_last;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(NUM_TIMERS))
        else $error("queue count beyond capacity");

    a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ($countones(running_reg) == 32'(count_reg)))
        else $error("running flags disagree with queue count");

    a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (32'(ram_waddr) < NUM_TIMERS))
        else $error("queue write outside storage");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !out_load)
        else $error("pending result overwritten");

endmodule

`default_nettype wire

[dv/tb.sv]
// ============================================================================
// tb : self-checking bench for sorted_deadline_timer_queue
// Drives start, stop, expire and unused-code commands over the slave stream. A
// scoreboard class keeps its own sorted copy of the timer queue and predicts
// every result transfer. Both stream sides idle at random in two of three phases.
// ============================================================================
`timescale 1ns / 1ps

module tb;
    import sdtq_pkg::*;

    localparam int N_ITEMS = 460;
    localparam int MAX_SHOWN = 10;
    localparam int DRAIN_CYCLES = 100;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam logic [NOW_W-1:0] TIME_MAX = '1;
    localparam logic [DELAY_W-1:0] DELAY_MAX = '1;

    typedef struct packed {
        status_t         status;
        logic [ID_W-1:0] id;
        logic            last;
    } timer_result_t;

    // sorted copy of the timer queue, plus the outstanding results
    class timer_scoreboard;
        logic [ID_W-1:0]  slot_id [DEF_NUM_TIMERS];
        logic [NOW_W-1:0] slot_deadline [DEF_NUM_TIMERS];
        bit               armed [DEF_NUM_TIMERS];
        int               depth;
        int               mismatches;
        timer_result_t    pending [$];

        function new();
            depth = 0;
            mismatches = 0;
            foreach (armed[i])
                armed[i] = 1'b0;
        endfunction

        function void add_pending(status_t st, logic [ID_W-1:0] id, logic last);
            timer_result_t r;
            r.status = st;
            r.id = id;
            r.last = last;
            pending.push_back(r);
        endfunction

        function void note_command(logic [FUNC_W-1:0] func, logic [ID_W-1:0] id,
                                   logic [NOW_W-1:0] now, logic [DELAY_W-1:0] delay);
            logic [NOW_W:0]   sum;
            logic [NOW_W-1:0] deadline;
            int               pos;
            int               due;
            int               i;
            case (func)
                FUNC_START:
                begin
                    if (armed[id] || depth >= DEF_NUM_TIMERS)
                        add_pending(ST_REJECT, '0, 1'b1);
                    else
                    begin
                        sum = now + delay;
                        deadline = sum[NOW_W] ? TIME_MAX : sum[NOW_W-1:0];
                        pos = 0;
                        while (pos < depth && slot_deadline[pos] <= deadline)
                            pos++;
                        for (i = depth; i > pos; i--)
                        begin
                            slot_id[i] = slot_id[i-1];
                            slot_deadline[i] = slot_deadline[i-1];
                        end
                        slot_id[pos] = id;
                        slot_deadline[pos] = deadline;
                        depth++;
                        armed[id] = 1'b1;
                        add_pending(ST_DONE, '0, 1'b1);
                    end
                end
                FUNC_STOP:
                begin
                    if (armed[id])
                    begin
                        pos = 0;
                        while (pos < depth && slot_id[pos] != id)
                            pos++;
                        if (pos < depth)
                        begin
                            for (i = pos; i + 1 < depth; i++)
                            begin
                                slot_id[i] = slot_id[i+1];
                                slot_deadline[i] = slot_deadline[i+1];
                            end
                            depth--;
                        end
                        armed[id] = 1'b0;
                    end
                    add_pending(ST_DONE, '0, 1'b1);
                end
                FUNC_EXPIRE:
                begin
                    due = 0;
                    while (due < depth && slot_deadline[due] <= now)
                        due++;
                    if (due == 0)
                        add_pending(ST_DONE, '0, 1'b1);
                    for (i = 0; i < due; i++)
                    begin
                        armed[slot_id[i]] = 1'b0;
                        add_pending(ST_FIRED, slot_id[i], i + 1 == due);
                    end
                    for (i = due; i < depth; i++)
                    begin
                        slot_id[i-due] = slot_id[i];
                        slot_deadline[i-due] = slot_deadline[i];
                    end
                    depth -= due;
                end
                default:
                    add_pending(ST_DONE, '0, 1'b1);
            endcase
        endfunction

        function void check_result(logic [STAT_W-1:0] st, logic [OUT_DATA_W-1:0] data,
                                   logic last);
            timer_result_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected transfer: status %0d data 0x%0h last %0d",
                             st, data, last);
            end
            else
            begin
                e = pending.pop_front();
                if (st !== e.status || data !== OUT_DATA_W'(e.id) || last !== e.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display({"mismatch: exp status %0d id %0d last %0d, ",
                                  "got status %0d data 0x%0h last %0d"},
                                 e.status, e.id, e.last, st, data, last);
                end
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [FUNC_W-1:0]     s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]     m_tuser;
    logic                  m_tlast;

    int src_idle_pct = 25;
    int rcv_idle_pct = 80;

    timer_scoreboard sb = new();

    sorted_deadline_timer_queue uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 clk = ~clk;

    // result side: sample the transfer, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata, m_tlast);
        m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    function automatic logic [NOW_W-1:0] rand_time();
        return {8'($urandom), 32'($urandom)};
    endfunction

    task automatic send_command(input logic [FUNC_W-1:0] func, input logic [ID_W-1:0] id,
                                input logic [NOW_W-1:0] now, input logic [DELAY_W-1:0] delay);
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {4'b0, delay, now, id};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_command(func, id, now, delay);
    endtask

    initial
    begin
        #20_000_000;
        $display("** sorted_deadline_timer_queue: FAILED **");
        $finish;
    end

    initial
    begin
        logic [NOW_W-1:0]   wall;
        logic [NOW_W-1:0]   now;
        logic [DELAY_W-1:0] delay;
        logic [ID_W-1:0]    id;
        int                 n;
        int                 r;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty expiry, reject, saturation, equal deadlines, idle stop
        send_command(FUNC_EXPIRE, 4'd0, '0, '0);
        send_command(FUNC_START, 4'd0, '0, '0);
        send_command(FUNC_START, 4'd0, 40'd5, 32'd5);
        send_command(FUNC_START, 4'd15, TIME_MAX, DELAY_MAX);
        send_command(FUNC_START, 4'd5, 40'd100, 32'd50);
        send_command(FUNC_START, 4'd6, 40'd100, 32'd50);
        send_command(FUNC_START, 4'd7, '0, 32'd150);
        send_command(FUNC_START, 4'd3, 40'd10, 32'd20);
        send_command(FUNC_STOP, 4'd9, TIME_MAX, DELAY_MAX);
        send_command(FUNC_STOP, 4'd6, '0, '0);
        send_command(FUNC_UNUSED, 4'd15, TIME_MAX, DELAY_MAX);
        send_command(FUNC_EXPIRE, 4'd15, 40'd149, DELAY_MAX);
        send_command(FUNC_EXPIRE, 4'd0, 40'd150, '0);
        send_command(FUNC_START, 4'd10, TIME_MAX - 40'd5, 32'd10);
        send_command(FUNC_START, 4'd11, TIME_MAX - 40'd1, 32'd1);
        send_command(FUNC_START, 4'd6, '0, DELAY_MAX);
        send_command(FUNC_STOP, 4'd3, '0, '0);
        send_command(FUNC_EXPIRE, 4'd0, TIME_MAX - 40'd1, '0);
        send_command(FUNC_EXPIRE, 4'd0, TIME_MAX, '0);
        send_command(FUNC_EXPIRE, 4'd0, TIME_MAX, '0);

        wall = rand_time();
        for (n = 20; n < N_ITEMS; n++)
        begin
            if (n == N_ITEMS / 3)
            begin
                src_idle_pct = 80;
                rcv_idle_pct = 25;
            end
            else if (n == 2 * N_ITEMS / 3)
            begin
                src_idle_pct = 0;
                rcv_idle_pct = 0;
            end

            // wall clock mostly creeps forward, now and then jumps
            r = $urandom_range(0, 99);
            if (r < 2)
                wall = rand_time();
            else if (r < 4)
                wall = TIME_MAX - $urandom_range(0, 300);
            else
                wall = wall + $urandom_range(0, 40);

            id = ID_W'($urandom_range(0, DEF_NUM_TIMERS - 1));
            now = ($urandom_range(0, 9) == 0) ? rand_time() : wall;
            r = $urandom_range(0, 99);
            delay = (r < 80) ? $urandom_range(0, 120) : (r < 95) ? $urandom : DELAY_MAX;

            r = $urandom_range(0, 99);
            if (r < 50)
                send_command(FUNC_START, id, now, delay);
            else if (r < 68)
                send_command(FUNC_STOP, id, rand_time(), $urandom);
            else if (r < 96)
                send_command(FUNC_EXPIRE, id, now, $urandom);
            else
                send_command(FUNC_UNUSED, id, rand_time(), $urandom);
        end
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.pending.size() != 0)
            $display("%0d results never arrived", sb.pending.size());
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("** sorted_deadline_timer_queue: PASSED **");
        else
            $display("** sorted_deadline_timer_queue: FAILED **");
        $finish;
    end

endmodule

[files.f]
rtl/core/sdtq_pkg.sv
rtl/core/sdtq_ram.sv
rtl/core/sdtq_alu.sv
rtl/core/sorted_deadline_timer_queue.sv
dv/tb.sv
